/* rtl/lts_pkg.sv */
// lts_pkg: shared types and constants for the LIFO stack with top-score query.
// Used by every module in rtl/.
`timescale 1ns / 1ps

package lts_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_TOP_K       = 3;
    localparam int TAG_W           = 16;
    localparam int SCORE_W         = 16;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_LIST = 2'd2,
        OP_TOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_FULL  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
    } t_entry;

    typedef struct packed {
        t_kind  kind;
        t_entry ent;
        logic   last;
    } t_result;

endpackage

/* rtl/lts_mem.sv */
// lts_mem: single-port-write, single-port-read entry store, registered read data.
// Depends on lts_pkg (t_entry).
`timescale 1ns / 1ps

module lts_mem #(
    parameter int DEPTH = lts_pkg::DEF_STACK_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  lts_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output lts_pkg::t_entry o_rdata
);

    lts_pkg::t_entry r_mem [DEPTH];
    lts_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/lts_topk.sv */
// lts_topk: sorted register list of the best TOP_K entries, one insertion per cycle.
// Depends on lts_pkg (t_entry).
`timescale 1ns / 1ps

module lts_topk #(
    parameter int TOP_K = lts_pkg::DEF_TOP_K,
    parameter int JW    = (TOP_K > 1) ? $clog2(TOP_K) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_ins,
    input  lts_pkg::t_entry i_ent,
    input  logic [JW-1:0]   i_sel,
    output lts_pkg::t_entry o_ent
);

    lts_pkg::t_entry r_ent [TOP_K];
    lts_pkg::t_entry n_ent [TOP_K];
    lts_pkg::t_entry prev_ent [TOP_K];
    logic [TOP_K-1:0] r_vld;
    logic [TOP_K-1:0] n_vld;
    logic [TOP_K-1:0] gt;
    logic [TOP_K-1:0] prev_gt;
    logic [TOP_K-1:0] prev_vld;

    // strict compare: ties keep the earlier-scanned (newer) entry ahead
    always_comb begin
        prev_gt     = '0;
        prev_vld    = '0;
        prev_ent[0] = '0;
        for (int j = 0; j < TOP_K; j++) begin
            gt[j] = !r_vld[j] || (i_ent.score > r_ent[j].score);
        end
        for (int j = 1; j < TOP_K; j++) begin
            prev_gt[j]  = gt[j-1];
            prev_vld[j] = r_vld[j-1];
            prev_ent[j] = r_ent[j-1];
        end
        for (int j = 0; j < TOP_K; j++) begin
            n_ent[j] = r_ent[j];
            n_vld[j] = r_vld[j];
            if (i_ins && gt[j]) begin
                if (!prev_gt[j]) begin
                    n_ent[j] = i_ent;
                    n_vld[j] = 1'b1;
                end else begin
                    n_ent[j] = prev_ent[j];
                    n_vld[j] = r_vld[j] || prev_vld[j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < TOP_K; j++) begin
            r_ent[j] <= n_ent[j];
        end
    end

    assign o_ent = r_ent[i_sel];

endmodule

/* rtl/lts_outq.sv */
// lts_outq: two-entry result queue that decouples the sequencer from the receiver.
// Depends on lts_pkg (t_result).
`timescale 1ns / 1ps

module lts_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_enq,
    input  lts_pkg::t_result i_data,
    input  logic             i_deq,
    output logic             o_valid,
    output lts_pkg::t_result o_data,
    output logic [1:0]       o_cnt,
    output logic             o_full
);

    lts_pkg::t_result r_mem [2];
    logic       r_head;
    logic [1:0] r_cnt;
    logic       wr_idx;

    assign wr_idx  = r_head ^ r_cnt[0];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cnt   = r_cnt;
    assign o_data  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_deq) begin
                r_head <= ~r_head;
            end
            r_cnt <= r_cnt + {1'b0, i_enq} - {1'b0, i_deq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enq) begin
            r_mem[wr_idx] <= i_data;
        end
    end

endmodule

/* rtl/lifo_stack_top_three_top.sv */
// lifo_stack_top_three_top: LIFO stack of (tag, score) entries with list and top-K query.
// Depends on lts_pkg, lts_mem, lts_topk, lts_outq.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one operation per transaction:
//   push, pop, list (newest first) or top-K by score. Output channel
//   (o_valid / i_ready) carries results; o_last marks the final result of
//   each operation. One operation is in progress at a time.
//   Sequencing, n = stored entries:
//     push, pop, any empty-stack case: one result, queued in the cycle of accept.
//     list: n entries, one entry per cycle while the receiver is ready,
//       paced by the single memory read port.
//     top-K: a scan of all n entries (one memory read per cycle), then
//       emission of min(n, TOP_K) entries while the queue has room.
//   Reset clears the entry count and all control state; entry memory is
//   not cleared. A stalled receiver holds results in a two-entry queue;
//   list reads are throttled by queue credit, so nothing is dropped, and
//   no new transaction is accepted until the current one has drained its
//   results into the queue.
`timescale 1ns / 1ps

module lifo_stack_top_three_top #(
    parameter int STACK_DEPTH = lts_pkg::DEF_STACK_DEPTH,
    parameter int TOP_K       = lts_pkg::DEF_TOP_K
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_tag,
    input  logic [15:0] i_score,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_tag_res,
    output logic [15:0] o_score_res,
    output logic        o_last
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int JW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int KW = $clog2(TOP_K + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LIST = 5'b00010,
        S_SCAN = 5'b00100,
        S_WAIT = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_pend, n_pend;
    logic            r_pend_list, n_pend_list;
    logic            r_pend_last, n_pend_last;
    logic [JW-1:0]   r_j, n_j;
    logic [KW-1:0]   r_want, n_want;

    logic            in_fire;
    logic            deq;
    logic [1:0]      q_cnt;
    logic            q_full;
    logic            q_valid;
    lts_pkg::t_result q_out;
    logic            enq;
    lts_pkg::t_result enq_data;

    logic            mem_we;
    logic            mem_re;
    lts_pkg::t_entry wr_ent;
    lts_pkg::t_entry rd_ent;
    lts_pkg::t_entry top_ent;
    logic            topk_clr;
    logic            topk_ins;
    logic [CW-1:0]   cnt_m1;
    logic [2:0]      credit;
    logic            emit_last;

    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_pend && !q_full;
    assign deq     = q_valid && i_ready;
    assign cnt_m1  = r_count - 1'b1;
    assign credit  = {1'b0, q_cnt} + {2'b00, r_pend};
    assign wr_ent  = '{tag: i_tag, score: i_score};
    assign emit_last = (32'(r_j) + 1 == 32'(r_want));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = 1'b0;
        n_pend_list = r_pend_list;
        n_pend_last = r_pend_last;
        n_j         = r_j;
        n_want      = r_want;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        topk_clr    = 1'b0;
        topk_ins    = 1'b0;
        enq         = 1'b0;
        enq_data    = '{kind: lts_pkg::KIND_DONE, ent: '0, last: 1'b1};

        if (r_pend) begin
            if (r_pend_list) begin
                enq      = 1'b1;
                enq_data = '{kind: lts_pkg::KIND_ENTRY, ent: rd_ent, last: r_pend_last};
            end else begin
                topk_ins = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    enq = 1'b1;
                    if (lts_pkg::t_op'(i_op) == lts_pkg::OP_PUSH) begin
                        if (32'(r_count) >= STACK_DEPTH) begin
                            enq_data.kind = lts_pkg::KIND_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_count == '0) begin
                        enq_data.kind = lts_pkg::KIND_EMPTY;
                    end else if (lts_pkg::t_op'(i_op) == lts_pkg::OP_POP) begin
                        n_count = cnt_m1;
                    end else begin
                        enq    = 1'b0;
                        n_addr = cnt_m1[AW-1:0];
                        if (lts_pkg::t_op'(i_op) == lts_pkg::OP_LIST) begin
                            n_state = S_LIST;
                        end else begin
                            topk_clr = 1'b1;
                            n_state  = S_SCAN;
                            if (32'(r_count) < TOP_K) begin
                                n_want = KW'(r_count);
                            end else begin
                                n_want = KW'(TOP_K);
                            end
                        end
                    end
                end
            end
            S_LIST: begin
                if (credit <= 3'd1 + {2'b00, deq}) begin
                    mem_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_list = 1'b1;
                    n_pend_last = (r_addr == '0);
                    if (r_addr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr = r_addr - 1'b1;
                    end
                end
            end
            S_SCAN: begin
                mem_re      = 1'b1;
                n_pend      = 1'b1;
                n_pend_list = 1'b0;
                n_pend_last = 1'b0;
                if (r_addr == '0) begin
                    n_state = S_WAIT;
                end else begin
                    n_addr = r_addr - 1'b1;
                end
            end
            S_WAIT: begin
                n_j     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!q_full) begin
                    enq      = 1'b1;
                    enq_data = '{kind: lts_pkg::KIND_ENTRY, ent: top_ent, last: emit_last};
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_pend_list <= 1'b0;
            r_pend_last <= 1'b0;
            r_j         <= '0;
            r_want      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_pend_list <= n_pend_list;
            r_pend_last <= n_pend_last;
            r_j         <= n_j;
            r_want      <= n_want;
        end
    end

    lts_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wr_ent),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (rd_ent)
    );

    lts_topk #(
        .TOP_K (TOP_K),
        .JW    (JW)
    ) u_topk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (topk_clr),
        .i_ins   (topk_ins),
        .i_ent   (rd_ent),
        .i_sel   (r_j),
        .o_ent   (top_ent)
    );

    lts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (enq),
        .i_data  (enq_data),
        .i_deq   (deq),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_cnt   (q_cnt),
        .o_full  (q_full)
    );

    assign o_valid     = q_valid;
    assign o_kind      = q_out.kind;
    assign o_tag_res   = q_out.ent.tag;
    assign o_score_res = q_out.ent.score;
    assign o_last      = q_out.last;

endmodule
